// ===== sv/ipph_pkg.sv =====
package ipph_pkg;

  localparam int unsigned DURATION_BITS_DEF = 16;
  localparam int unsigned COUNT_BITS        = 8;
  localparam int unsigned HASH_BITS         = 32;
  localparam int unsigned QUEUE_DEPTH       = 2;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX         = 8'd255;
  localparam logic [COUNT_BITS-1:0] FIRST_HASHED_POS  = 8'd3;
  localparam logic [COUNT_BITS-1:0] MIN_SAMPLES_RESET = 8'd6;

  localparam logic [HASH_BITS-1:0] FNV1_PRIME = 32'd16777619;
  localparam logic [HASH_BITS-1:0] FNV1_BASIS = 32'd2166136261;

  typedef enum logic [1:0] {
    SYM_SHORTER = 2'd0,
    SYM_EQUAL   = 2'd1,
    SYM_LONGER  = 2'd2
  } sym_t;

  // one classified item handed from front to back
  typedef struct packed {
    sym_t sym;
    logic do_hash;
    logic last;
    logic ok;
  } rec_t;

endpackage

// ===== sv/ipph_front.sv =====
module ipph_front #(
  parameter int unsigned DURATION_BITS = ipph_pkg::DURATION_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                take,
  input  logic [DURATION_BITS-1:0]            duration,
  input  logic                                last,
  input  logic [ipph_pkg::COUNT_BITS-1:0]     min_samples,
  output ipph_pkg::rec_t                      rec
);

  localparam int unsigned PW = DURATION_BITS + 3;

  logic [DURATION_BITS-1:0]        prev_one_r, prev_two_r;
  logic [ipph_pkg::COUNT_BITS-1:0] count_r, count_nxt;
  logic [PW-1:0]                   new5, old5, new4, old4;

  // 5*new vs 4*old, exact integer form of the 20% window
  assign new4 = PW'(duration) << 2;
  assign old4 = PW'(prev_two_r) << 2;
  assign new5 = new4 + PW'(duration);
  assign old5 = old4 + PW'(prev_two_r);

  assign count_nxt = (count_r == ipph_pkg::COUNT_MAX) ? ipph_pkg::COUNT_MAX
                                                      : count_r + 1'b1;

  always_comb begin
    if (new5 < old4) begin
      rec.sym = ipph_pkg::SYM_SHORTER;
    end else if (old5 < new4) begin
      rec.sym = ipph_pkg::SYM_LONGER;
    end else begin
      rec.sym = ipph_pkg::SYM_EQUAL;
    end
    rec.do_hash = (count_r >= ipph_pkg::FIRST_HASHED_POS);
    rec.last    = last;
    rec.ok      = (count_nxt >= min_samples);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_one_r <= '0;
      prev_two_r <= '0;
      count_r    <= '0;
    end else if (take) begin
      if (last) begin
        prev_one_r <= '0;
        prev_two_r <= '0;
        count_r    <= '0;
      end else begin
        prev_one_r <= duration;
        prev_two_r <= prev_one_r;
        count_r    <= count_nxt;
      end
    end
  end

endmodule

// ===== sv/ipph_queue.sv =====
module ipph_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ipph_pkg::rec_t push_rec,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output ipph_pkg::rec_t pop_rec
);

  localparam int unsigned PTR_BITS = (ipph_pkg::QUEUE_DEPTH > 1)
                                   ? $clog2(ipph_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_BITS = $clog2(ipph_pkg::QUEUE_DEPTH + 1);

  ipph_pkg::rec_t       slot_r [ipph_pkg::QUEUE_DEPTH];
  logic [PTR_BITS-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_BITS-1:0]  fill_r;

  assign full    = (fill_r == CNT_BITS'(ipph_pkg::QUEUE_DEPTH));
  assign empty   = (fill_r == '0);
  assign pop_rec = slot_r[rd_ptr_r];

  function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
    if (p == PTR_BITS'(ipph_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_rec;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (pop && !push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

endmodule

// ===== sv/ipph_back.sv =====
module ipph_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               rec_avail,
  input  ipph_pkg::rec_t                     rec,
  output logic                               rec_pop,
  output logic                               res_valid,
  input  logic                               res_ready,
  output logic [ipph_pkg::HASH_BITS-1:0]     res_hash,
  output logic                               res_ok
);

  logic [ipph_pkg::HASH_BITS-1:0] running_r, mix, hash_use;
  logic                           res_valid_r, res_valid_nxt, res_ok_r;
  logic [ipph_pkg::HASH_BITS-1:0] res_hash_r;

  assign rec_pop  = rec_avail && (!res_valid_r || res_ready);
  // fnv-1 step: multiply mod 2^32, then xor the symbol
  assign mix      = (running_r * ipph_pkg::FNV1_PRIME)
                  ^ ipph_pkg::HASH_BITS'(rec.sym);
  assign hash_use = rec.do_hash ? mix : running_r;

  assign res_valid = res_valid_r;
  assign res_hash  = res_hash_r;
  assign res_ok    = res_ok_r;

  // result drops when taken, a last item loads a new one
  always_comb begin
    res_valid_nxt = res_valid_r && !res_ready;
    if (rec_pop && rec.last) begin
      res_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r   <= ipph_pkg::FNV1_BASIS;
      res_valid_r <= 1'b0;
      res_ok_r    <= 1'b0;
      res_hash_r  <= '0;
    end else begin
      res_valid_r <= res_valid_nxt;
      if (rec_pop) begin
        if (rec.last) begin
          running_r   <= ipph_pkg::FNV1_BASIS;
          res_ok_r    <= rec.ok;
          res_hash_r  <= rec.ok ? hash_use : '0;
        end else begin
          running_r <= hash_use;
        end
      end
    end
  end

endmodule

// ===== sv/ir_pulse_pattern_hash.sv =====
// an item's result reaches out_* through a queue slot, then the output register, and is
//   held back while out_tready is low
// throughput: one item per cycle while the queue has room, set by the combinational fnv multiply in the back end
// reset: synchronous active-low rst_n clears the burst state, empties the queue,
//   drops any pending result and sets min_samples to 6
module ir_pulse_pattern_hash #(
  parameter int unsigned DURATION_BITS = ipph_pkg::DURATION_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // input stream of pulse durations
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  input  logic [((DURATION_BITS + 7) / 8) * 8-1:0] in_tdata,  // duration, zero pad
  input  logic                                    in_tlast,  // last duration of burst
  // result stream, one item per burst
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  output logic [ipph_pkg::HASH_BITS-1:0]          out_tdata, // hash
  output logic                                    out_tuser, // valid_res
  // min_samples write channel
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [ipph_pkg::COUNT_BITS-1:0]         cfg_data   // min_samples
);

  logic [ipph_pkg::COUNT_BITS-1:0] min_samples_r;
  logic                            q_full, q_empty, q_pop, in_take;
  ipph_pkg::rec_t                  front_rec, q_rec;

  // register writes always accepted; do them only while idle, the block does not enforce this
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_samples_r <= ipph_pkg::MIN_SAMPLES_RESET;
    end else if (cfg_valid) begin
      min_samples_r <= cfg_data;
    end
  end

  // front end takes an item whenever the queue has room
  assign in_tready = !q_full;
  assign in_take   = in_tvalid && in_tready;

  // front: tracks the two previous durations and the count, classifies each item
  ipph_front #(
    .DURATION_BITS(DURATION_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (in_take),
    .duration    (in_tdata[DURATION_BITS-1:0]),
    .last        (in_tlast),
    .min_samples (min_samples_r),
    .rec         (front_rec)
  );

  // short queue decouples front from back
  ipph_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_take),
    .push_rec (front_rec),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .pop_rec  (q_rec)
  );

  // back: folds symbols into the running hash and holds the result
  ipph_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec_avail (!q_empty),
    .rec       (q_rec),
    .rec_pop   (q_pop),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res_hash  (out_tdata),
    .res_ok    (out_tuser)
  );

endmodule
